>>> hdl/rgbc_pkg.sv
`timescale 1ns / 1ps
// rgbc_pkg: types, codes and constants shared by the rgb 3x3 convolution block
// no dependencies

package rgbc_pkg;

    // one rgb pixel packed as red, green, blue (red in the top byte)
    localparam int PIX_W = 24;
    typedef logic [PIX_W-1:0] t_pixel;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int KERN_BITS   = 63;
    localparam int DIV_BITS    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_KERNEL  = 2'd2,
        CFG_DIVISOR = 2'd3
    } t_cfg_idx;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST   = 11'd256;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST  = 13'd256;
    localparam logic [KERN_BITS-1:0]   KERNEL_RST  = 63'h0000_0000_1000_0000;
    localparam logic [DIV_BITS-1:0]    DIVISOR_RST = 8'd1;

    // input item operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // arithmetic sizes: |sum| <= 9 * 255 * 64 fits 18 bits of magnitude
    localparam int COEF_W = 7;
    localparam int PROD_W = 16;
    localparam int ACC_W  = 19;
    localparam int QW     = ACC_W - 1;
    localparam int TAPS   = 9;
    localparam int TAP_W  = 4;
    localparam int CNT_W  = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MAC,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             take;      // latch request, start line buffer read
        logic             shift;     // update window and line buffers
        logic             mac_clr;
        logic             mac_en;
        logic [TAP_W-1:0] tap;
        logic             second;    // result centered on the newest column
        logic             div_load;
        logic             div_step;
        logic             out_load;
        logic             advance;   // step the raster position
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hdl/rgbc_pix_if.sv
`timescale 1ns / 1ps
// rgbc_pix_if: input pixel channel, valid/ready with operation and rgb payload
// no dependencies

interface rgbc_pix_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output operation, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input operation, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

>>> hdl/rgbc_res_if.sv
`timescale 1ns / 1ps
// rgbc_res_if: result channel, valid/ready with filtered rgb and framing flags
// no dependencies

interface rgbc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_in_run;
    logic       end_of_row;
    logic       end_of_frame;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output last_in_run, output end_of_row, output end_of_frame,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input last_in_run, input end_of_row, input end_of_frame,
                    output ready);
endinterface

>>> hdl/rgbc_ram.sv
`timescale 1ns / 1ps
// rgbc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rgbc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rgbc_ctrl.sv
`timescale 1ns / 1ps
// rgbc_ctrl: sequencer for one request at a time (shift, multiply-accumulate, divide, output)
// depends on rgbc_pkg

module rgbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rgbc_pkg::t_dp_sts i_sts,
    output rgbc_pkg::t_dp_cmd o_cmd
);
    import rgbc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_second   = r_second;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.second = r_second;
        o_cmd.tap    = r_cnt[TAP_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_cnt       = '0;
                if (i_sts.emit_a || i_sts.emit_b) begin
                    // left-centered result first when both are due
                    n_second      = !i_sts.emit_a;
                    o_cmd.mac_clr = 1'b1;
                    n_state       = ST_MAC;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_MAC: begin
                o_cmd.mac_en = 1'b1;
                if (r_cnt == CNT_W'(TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DLOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (!r_second && i_sts.emit_b) begin
                        n_second      = 1'b1;
                        o_cmd.mac_clr = 1'b1;
                        n_state       = ST_MAC;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/rgbc_dp.sv
`timescale 1ns / 1ps
// rgbc_dp: config registers, raster position, line buffers, 3x3 window,
// per-channel multiply-accumulate, bit-serial dividers and output register
// depends on rgbc_pkg and rgbc_ram

module rgbc_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  rgbc_pkg::t_dp_cmd                  i_cmd,
    output rgbc_pkg::t_dp_sts                  o_sts,
    input  logic                               i_operation,
    input  logic [7:0]                         i_red_in,
    input  logic [7:0]                         i_green_in,
    input  logic [7:0]                         i_blue_in,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic                               o_last_in_run,
    output logic                               o_end_of_row,
    output logic                               o_end_of_frame
);
    import rgbc_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int WX  = (WCW > WIDTH_BITS) ? WCW : WIDTH_BITS;
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int HX  = (RW > HEIGHT_BITS) ? RW : HEIGHT_BITS;

    // configuration
    logic [WIDTH_BITS-1:0]  r_cfg_width;
    logic [HEIGHT_BITS-1:0] r_cfg_height;
    logic [KERN_BITS-1:0]   r_kern;
    logic [DIV_BITS-1:0]    r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_kern       <= KERNEL_RST;
            r_div        <= DIVISOR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:   r_cfg_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT:  r_cfg_height <= i_cfg_data[HEIGHT_BITS-1:0];
                CFG_KERNEL:  r_kern       <= i_cfg_data[KERN_BITS-1:0];
                CFG_DIVISOR: r_div        <= i_cfg_data[DIV_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // sizes clamped to 1..max, divisor zero taken as one
    logic [WX-1:0]       w_ext;
    logic [HX-1:0]       h_ext;
    logic [WCW-1:0]      w_eff;
    logic [RW-1:0]       h_eff;
    logic [DIV_BITS-1:0] d_eff;

    always_comb begin
        w_ext = WX'(r_cfg_width);
        h_ext = HX'(r_cfg_height);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WX'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(w_ext);
        end
        if (h_ext == '0) begin
            h_eff = RW'(1);
        end else if (h_ext > HX'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(h_ext);
        end
        d_eff = (r_div == '0) ? DIV_BITS'(1) : r_div;
    end

    // raster position and latched request
    logic [CW-1:0] r_col, eff_col;
    logic [RW-1:0] r_row, eff_row;
    logic          restart;
    logic          r_op;
    t_pixel        r_pix;
    logic [WCW-1:0] col_inc;
    logic [RW:0]    row_inc;

    assign restart = ({1'b0, r_col} >= WCW'(w_eff)) || (r_row > h_eff);
    assign eff_col = restart ? '0 : r_col;
    assign eff_row = restart ? '0 : r_row;
    assign col_inc = WCW'(r_col) + WCW'(1);
    assign row_inc = {1'b0, r_row} + (RW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.take) begin
            r_col <= eff_col;
            r_row <= eff_row;
        end else if (i_cmd.advance) begin
            if (col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= (row_inc > {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op  <= i_operation;
            r_pix <= {i_red_in, i_green_in, i_blue_in};
        end
    end

    // line buffers: above in the upper half, middle in the lower half
    logic [2*PIX_W-1:0] line_rdata;
    t_pixel             up_pix, mid_pix, new_pix;

    assign up_pix  = line_rdata[2*PIX_W-1:PIX_W];
    assign mid_pix = line_rdata[PIX_W-1:0];
    assign new_pix = (r_op == OP_PIXEL && r_row < h_eff) ? r_pix : '0;

    rgbc_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_col),
        .i_wdata ({mid_pix, new_pix}),
        .i_re    (i_cmd.take),
        .i_raddr (eff_col),
        .o_rdata (line_rdata)
    );

    // 3x3 window, column 2 is the newest
    t_pixel r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= up_pix;
            r_win[1][2] <= mid_pix;
            r_win[2][2] <= new_pix;
        end
    end

    // emission and border flags
    logic row_ge1, top_ok, bot_ok, left_ok, right_ok, is_last_col;

    assign row_ge1     = (r_row != '0);
    assign is_last_col = ({1'b0, r_col} == (w_eff - WCW'(1)));
    assign top_ok      = (r_row >= RW'(2));
    assign bot_ok      = (r_row < h_eff);
    assign left_ok     = i_cmd.second ? (w_eff >= WCW'(2)) : (r_col >= CW'(2));
    assign right_ok    = !i_cmd.second;

    assign o_sts.emit_a   = row_ge1 && (r_col != '0);
    assign o_sts.emit_b   = row_ge1 && is_last_col;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // tap decode and operand selection
    logic [1:0]               tap_r, tap_c, win_c, win_sel;
    logic                     tap_use;
    logic [5:0]               kofs;
    logic signed [COEF_W-1:0] coef;
    t_pixel                   tap_pix;

    always_comb begin
        case (i_cmd.tap)
            4'd0:    begin tap_r = 2'd0; tap_c = 2'd0; end
            4'd1:    begin tap_r = 2'd0; tap_c = 2'd1; end
            4'd2:    begin tap_r = 2'd0; tap_c = 2'd2; end
            4'd3:    begin tap_r = 2'd1; tap_c = 2'd0; end
            4'd4:    begin tap_r = 2'd1; tap_c = 2'd1; end
            4'd5:    begin tap_r = 2'd1; tap_c = 2'd2; end
            4'd6:    begin tap_r = 2'd2; tap_c = 2'd0; end
            4'd7:    begin tap_r = 2'd2; tap_c = 2'd1; end
            4'd8:    begin tap_r = 2'd2; tap_c = 2'd2; end
            default: begin tap_r = 2'd0; tap_c = 2'd0; end
        endcase
        win_c   = tap_c + {1'b0, i_cmd.second};
        win_sel = (win_c == 2'd3) ? 2'd2 : win_c;
        tap_use = !(tap_r == 2'd0 && !top_ok) && !(tap_r == 2'd2 && !bot_ok) &&
                  !(tap_c == 2'd0 && !left_ok) && !(tap_c == 2'd2 && !right_ok) &&
                  (win_c != 2'd3);
        kofs    = 6'(i_cmd.tap) * 6'd7;
        coef    = signed'(r_kern[kofs +: COEF_W]);
        tap_pix = r_win[tap_r][win_sel];
    end

    // per-channel multiply-accumulate and restoring divider (red is channel 0)
    logic signed [PROD_W-1:0] prod [3];
    logic signed [ACC_W-1:0]  r_acc [3];
    logic                     r_neg [3];
    logic [QW-1:0]            r_dvd [3];
    logic [DIV_BITS-1:0]      r_rem [3];
    logic [DIV_BITS:0]        trial [3];
    logic                     fits [3];
    logic [7:0]               quo [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch]  = PROD_W'($signed({1'b0, tap_pix[8*(2-ch) +: 8]})) * PROD_W'(coef);
            trial[ch] = {r_rem[ch], r_dvd[ch][QW-1]};
            fits[ch]  = (trial[ch] >= {1'b0, d_eff});
            quo[ch]   = r_neg[ch] ? (~r_dvd[ch][7:0] + 8'd1) : r_dvd[ch][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            if (i_cmd.mac_clr) begin
                r_acc[ch] <= '0;
            end else if (i_cmd.mac_en && tap_use) begin
                r_acc[ch] <= r_acc[ch] + ACC_W'(prod[ch]);
            end
            if (i_cmd.div_load) begin
                r_neg[ch] <= r_acc[ch][ACC_W-1];
                r_dvd[ch] <= r_acc[ch][ACC_W-1] ? QW'(-r_acc[ch]) : QW'(r_acc[ch]);
                r_rem[ch] <= '0;
            end else if (i_cmd.div_step) begin
                r_rem[ch] <= fits[ch] ? DIV_BITS'(trial[ch] - {1'b0, d_eff})
                                      : trial[ch][DIV_BITS-1:0];
                r_dvd[ch] <= {r_dvd[ch][QW-2:0], fits[ch]};
            end
        end
    end

    // output register
    logic r_out_valid, r_last, r_eor, r_eof;
    logic [7:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_red   <= quo[0];
            r_green <= quo[1];
            r_blue  <= quo[2];
            r_last  <= i_cmd.second || !o_sts.emit_b;
            r_eor   <= i_cmd.second;
            r_eof   <= i_cmd.second && (r_row == h_eff);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red_out      = r_red;
    assign o_green_out    = r_green;
    assign o_blue_out     = r_blue;
    assign o_last_in_run  = r_last;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

>>> hdl/rgb_convolution_3x3.sv
`timescale 1ns / 1ps
// rgb_convolution_3x3: top level, streaming 3x3 convolution of an rgb raster
// depends on rgbc_pkg, rgbc_pix_if, rgbc_res_if, rgbc_ctrl, rgbc_dp, rgbc_ram

// Pixels enter in raster order on i_pix; after each frame one row of drain
// requests (operation = 1) stands for the row below the image. Each channel's
// result is the sum of the in-image 3x3 neighbors times nine signed 7-bit
// coefficients, divided by the divisor (truncating toward zero), low 8 bits
// kept. A request at row r >= 1 gives the result centered one row up and one
// column left (if not the first column), and at the row's last column also
// the one centered on that column. One request is worked at a time; one with
// no result only shifts the window and steps the position. Each result passes
// through the per-channel multiply-accumulate, one tap a cycle, a divider load,
// the bit-serial divider and the output register, in that order; it waits only
// if o_res stalls with a result still held. A finished result waits in the
// output register while the next request is taken. Line buffers are one ram of
// MAX_WIDTH x 48 bits and need no clearing pass after reset. The user must write
// configuration on the plain write port only while the block is idle; the block
// itself does not enforce this.

module rgb_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rgbc_pix_if.sink                        i_pix,
    rgbc_res_if.source                      o_res
);
    import rgbc_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: owns request acceptance and the tap / divide step counter
    rgbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: position, line buffers, window, arithmetic, output register
    rgbc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_pix.operation),
        .i_red_in       (i_pix.red_in),
        .i_green_in     (i_pix.green_in),
        .i_blue_in      (i_pix.blue_in),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_red_out      (o_res.red_out),
        .o_green_out    (o_res.green_out),
        .o_blue_out     (o_res.blue_out),
        .o_last_in_run  (o_res.last_in_run),
        .o_end_of_row   (o_res.end_of_row),
        .o_end_of_frame (o_res.end_of_frame)
    );

endmodule

>>> hdl/rgbc_checker.sv
`timescale 1ns / 1ps
// rgbc_checker: port-level assertions for rgb_convolution_3x3, bound to the top
// depends on rgb_convolution_3x3 (bind target)

module rgbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red_out,
    input logic [7:0] i_green_out,
    input logic [7:0] i_blue_out,
    input logic       i_last_in_run,
    input logic       i_end_of_row,
    input logic       i_end_of_frame
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red_out) &&
        $stable(i_green_out) && $stable(i_blue_out) && $stable(i_last_in_run) &&
        $stable(i_end_of_row) && $stable(i_end_of_frame))
        else $error("result changed while stalled");

    // one request at a time: ready drops right after a request is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in work");

    // a new result needs at least the window update and the arithmetic
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result appeared too soon after request");

    // frame end only on the closing result of a row and of its request
    a_eof_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_of_frame |-> i_end_of_row && i_last_in_run)
        else $error("end of frame without end of row and last in run");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind rgb_convolution_3x3 rgbc_checker u_rgbc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pix.valid),
    .i_in_ready     (i_pix.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_red_out      (o_res.red_out),
    .i_green_out    (o_res.green_out),
    .i_blue_out     (o_res.blue_out),
    .i_last_in_run  (o_res.last_in_run),
    .i_end_of_row   (o_res.end_of_row),
    .i_end_of_frame (o_res.end_of_frame)
);
